// ===== rtl/ita_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ita_pkg
// Types and constants of the integer to ASCII formatter: the request and
// character payloads, operand size codes and character codes.
// ----------------------------------------------------------------------------
package ita_pkg;

  localparam int VALUE_W = 64;
  localparam int FIELD_WIDTH_W = 6;
  localparam int BIT_CNT_W = 7;

  localparam int DEF_MAX_FIELD_WIDTH = 62;
  localparam int DEF_DIGIT_SLOTS = 20;

  localparam logic [1:0] SIZE_32 = 2'd0;
  localparam logic [1:0] SIZE_8 = 2'd1;
  localparam logic [1:0] SIZE_16 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  typedef struct packed {
    logic [VALUE_W-1:0]       value;
    logic [1:0]               operand_size;
    logic                     hex_mode;
    logic                     is_signed;
    logic                     show_plus;
    logic                     upper_case;
    logic                     alt_prefix;
    logic                     left_justify;
    logic                     zero_pad;
    logic [FIELD_WIDTH_W-1:0] field_width;
  } req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } res_t;

endpackage

// ===== rtl/integer_to_ascii_formatter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one integer conversion request as a stream of ASCII characters.
// ----------------------------------------------------------------------------
// A request enters on req when req_valid and req_ready are both high. Its
// characters leave on res, one per accepted transfer, with last_char set on
// the final one. Prefix, padding, sign and digits come out in that order,
// with right padding after the digits when left justified.
// A decimal request runs a bit-serial binary to BCD conversion, one value bit
// per cycle over the operand size (8, 16, 32 or 64 bits). A hex request
// loads its nibbles directly. Leading zero digits are then dropped one per
// cycle, at most DIGIT_SLOTS - 1 of them. After that one character is loaded
// per cycle into the output register while the receiver takes them.
// req_ready is high only between requests; the next request is taken while
// the last character still waits in the output register.
// When the receiver stalls, the held character stays on res and emission
// pauses. Reset empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
  parameter int MAX_FIELD_WIDTH = ita_pkg::DEF_MAX_FIELD_WIDTH,
  parameter int DIGIT_SLOTS = ita_pkg::DEF_DIGIT_SLOTS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ita_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output ita_pkg::res_t res
);

  localparam int DW = 4 * DIGIT_SLOTS;
  localparam int CW = $clog2(DIGIT_SLOTS + 1);
  localparam int SPAN_MAX = (MAX_FIELD_WIDTH > DIGIT_SLOTS + 1) ?
                            MAX_FIELD_WIDTH : DIGIT_SLOTS + 1;
  localparam int TW = $clog2(SPAN_MAX + 3);
  localparam int VW = ita_pkg::VALUE_W;
  localparam int FW = ita_pkg::FIELD_WIDTH_W;
  localparam int BW = ita_pkg::BIT_CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_CONVERT = 4'b0010,
    ST_TRIM    = 4'b0100,
    ST_EMIT    = 4'b1000
  } state_t;

  state_t          state;
  logic [VW-1:0]   bin;
  logic [BW-1:0]   bit_cnt;
  logic [DW-1:0]   digs;
  logic [CW-1:0]   dig_cnt;
  logic [1:0]      pfx_cnt;
  logic [FW-1:0]   pad;
  logic [FW-1:0]   width;
  logic [TW-1:0]   total;
  logic            sign_pend;
  logic [7:0]      sign_ch;
  logic            upper;
  logic            left;
  logic            zpad;

  logic [VW-1:0]   mask;
  logic            top_bit;
  logic [VW-1:0]   narrowed;
  logic [VW-1:0]   extended;
  logic            negative;
  logic [VW-1:0]   magnitude;
  logic [VW-1:0]   aligned;
  logic [BW-1:0]   size_bits;
  logic [FW-1:0]   width_sat;
  logic [DW-1:0]   corrected;
  logic [3:0]      top_digit;
  logic [TW-1:0]   len;
  logic [TW-1:0]   wid;
  logic            sel_pfx;
  logic            sel_pad;
  logic            sel_sign;
  logic            sel_dig;
  logic [7:0]      emit_ch;
  logic            emit_go;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
    logic [7:0] base;
    base = up ? ita_pkg::CH_UPPER_A : ita_pkg::CH_LOWER_A;
    if (d < 4'd10) begin
      digit_char = ita_pkg::CH_ZERO + {4'b0, d};
    end else begin
      digit_char = base + {4'b0, d - 4'd10};
    end
  endfunction

  always_comb begin
    case (req.operand_size)
      ita_pkg::SIZE_8: begin
        mask = {{(VW-8){1'b0}}, {8{1'b1}}};
        top_bit = req.value[7];
        size_bits = BW'(8);
      end
      ita_pkg::SIZE_16: begin
        mask = {{(VW-16){1'b0}}, {16{1'b1}}};
        top_bit = req.value[15];
        size_bits = BW'(16);
      end
      ita_pkg::SIZE_32: begin
        mask = {{(VW-32){1'b0}}, {32{1'b1}}};
        top_bit = req.value[31];
        size_bits = BW'(32);
      end
      default: begin
        mask = {VW{1'b1}};
        top_bit = req.value[VW-1];
        size_bits = BW'(64);
      end
    endcase
    narrowed = req.value & mask;
    negative = !req.hex_mode && req.is_signed && top_bit;
    extended = negative ? (narrowed | ~mask) : narrowed;
    magnitude = negative ? (~extended + VW'(1)) : extended;
    case (req.operand_size)
      ita_pkg::SIZE_8:  aligned = magnitude << (VW - 8);
      ita_pkg::SIZE_16: aligned = magnitude << (VW - 16);
      ita_pkg::SIZE_32: aligned = magnitude << (VW - 32);
      default:          aligned = magnitude;
    endcase
    width_sat = (req.field_width > FW'(MAX_FIELD_WIDTH)) ? FW'(MAX_FIELD_WIDTH) :
                req.field_width;
  end

  always_comb begin
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      corrected[4*i +: 4] = (digs[4*i +: 4] >= 4'd5) ? digs[4*i +: 4] + 4'd3 :
                            digs[4*i +: 4];
    end
  end

  assign top_digit = digs[DW-1 -: 4];
  assign len = TW'(dig_cnt) + TW'(sign_pend);
  assign wid = TW'(width);

  always_comb begin
    sel_pfx = pfx_cnt != 2'd0;
    sel_pad = !sel_pfx && !left && pad != '0;
    sel_sign = !sel_pfx && !sel_pad && sign_pend;
    sel_dig = !sel_pfx && !sel_pad && !sign_pend && dig_cnt != '0;
    if (sel_pfx) begin
      emit_ch = (pfx_cnt == 2'd2) ? ita_pkg::CH_ZERO :
                (upper ? ita_pkg::CH_UPPER_X : ita_pkg::CH_LOWER_X);
    end else if (sel_pad) begin
      emit_ch = zpad ? ita_pkg::CH_ZERO : ita_pkg::CH_SPACE;
    end else if (sel_sign) begin
      emit_ch = sign_ch;
    end else if (sel_dig) begin
      emit_ch = digit_char(top_digit, upper);
    end else begin
      emit_ch = ita_pkg::CH_SPACE;
    end
  end

  assign req_ready = state == ST_IDLE;
  assign emit_go = (state == ST_EMIT) && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_ready && !emit_go) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            upper <= req.upper_case;
            left <= req.left_justify;
            zpad <= req.zero_pad;
            width <= width_sat;
            pfx_cnt <= (req.hex_mode && req.alt_prefix) ? 2'd2 : 2'd0;
            sign_pend <= !req.hex_mode && (negative || req.show_plus);
            sign_ch <= negative ? ita_pkg::CH_MINUS : ita_pkg::CH_PLUS;
            bin <= aligned;
            bit_cnt <= size_bits;
            dig_cnt <= CW'(DIGIT_SLOTS);
            if (req.hex_mode) begin
              digs <= {{(DW-VW){1'b0}}, narrowed};
              state <= ST_TRIM;
            end else begin
              digs <= '0;
              state <= ST_CONVERT;
            end
          end
        end
        ST_CONVERT: begin
          digs <= {corrected[DW-2:0], bin[VW-1]};
          bin <= bin << 1;
          bit_cnt <= bit_cnt - BW'(1);
          if (bit_cnt == BW'(1)) begin
            state <= ST_TRIM;
          end
        end
        ST_TRIM: begin
          if (dig_cnt > CW'(1) && top_digit == 4'd0) begin
            digs <= digs << 4;
            dig_cnt <= dig_cnt - CW'(1);
          end else begin
            pad <= (wid > len) ? FW'(wid - len) : '0;
            total <= ((wid > len) ? wid : len) + TW'(pfx_cnt);
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            res_valid <= 1'b1;
            res.out_char <= emit_ch;
            res.last_char <= total == TW'(1);
            total <= total - TW'(1);
            if (sel_pfx) begin
              pfx_cnt <= pfx_cnt - 2'd1;
            end
            if (sel_pad) begin
              pad <= pad - FW'(1);
            end
            if (sel_sign) begin
              sign_pend <= 1'b0;
            end
            if (sel_dig) begin
              digs <= digs << 4;
              dig_cnt <= dig_cnt - CW'(1);
            end
            if (total == TW'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
